@@ rtl/assert_macros.svh @@
// assertion macros used by shared_memory_dual_stack.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define SMDS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("smds assertion failed");

// condition that must never be true outside reset
`define SMDS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("smds forbidden condition seen");

`endif

@@ rtl/smds_pkg.sv @@
// types, constants and codes of the shared-memory dual stack
package smds_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SCORE_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [SCORE_W-1:0] THRESH_RESET = SCORE_W'(70);

    // operation and stack codes
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_POP   = 1'b1;
    localparam logic SEL_LOWER  = 1'b0;
    localparam logic SEL_UPPER  = 1'b1;

    // register index decoded from paddr
    localparam logic REG_ROUTE_THRESHOLD = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                  func;
        logic [DATA_WIDTH-1:0] entry_data;
        logic [SCORE_W-1:0]    score;
        logic                  stack_select;
    } req_t;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] wdata;
    } mem_req_t;

    // what travels with an item while its memory read completes
    typedef struct packed {
        status_t status;
        logic    went_upper;
        logic    rd_ok;
    } op_info_t;

    typedef struct packed {
        logic [CNT_W-1:0] lower_count;
        logic [CNT_W-1:0] upper_count;
    } cnt_state_t;

endpackage

@@ rtl/smds_if.sv @@
// handshake channels: operation requests in, results out
interface smds_req_if;
    import smds_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [DATA_WIDTH-1:0] entry_data;
    logic [SCORE_W-1:0]    score;
    logic                  stack_select;

    modport source (output valid, func, entry_data, score, stack_select, input ready);
    modport sink   (input valid, func, entry_data, score, stack_select, output ready);
endinterface

interface smds_rsp_if;
    import smds_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] read_data;
    logic [STATUS_W-1:0]   status;
    logic                  went_upper;

    modport source (output valid, read_data, status, went_upper, input ready);
    modport sink   (input valid, read_data, status, went_upper, output ready);
endinterface

@@ rtl/smds_cfg.sv @@
// apb register block holding the routing threshold
module smds_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [smds_pkg::APB_AW-1:0]  paddr,
    input  logic [smds_pkg::APB_DW-1:0]  pwdata,
    output logic [smds_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output logic [smds_pkg::SCORE_W-1:0] route_threshold
);
    import smds_pkg::*;

    logic [SCORE_W-1:0] thresh_reg;
    logic [SCORE_W-1:0] thresh_next;
    logic               reg_index;
    logic               wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite && pready
                       && (reg_index == REG_ROUTE_THRESHOLD);

    always_comb
    begin
        thresh_next = thresh_reg;
        if (wr_en)
        begin
            thresh_next = pwdata[SCORE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_ROUTE_THRESHOLD)
        begin
            prdata = {{(APB_DW-SCORE_W){1'b0}}, thresh_reg};
        end
    end

    assign route_threshold = thresh_reg;

endmodule

@@ rtl/smds_mem.sv @@
// shared entry store, one write or one registered read per cycle
module smds_mem (
    input  logic                            clk,
    input  smds_pkg::mem_req_t              mem_req,
    output logic [smds_pkg::DATA_WIDTH-1:0] rdata
);
    import smds_pkg::*;

    logic [DATA_WIDTH-1:0] mem_array [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem_array[mem_req.addr] <= mem_req.wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rdata_reg <= mem_array[mem_req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/smds_ctrl.sv @@
// stack pointers, routing and memory request generation
module smds_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  smds_pkg::req_t               req,
    input  logic [smds_pkg::SCORE_W-1:0] route_threshold,
    output smds_pkg::mem_req_t           mem_req,
    output smds_pkg::op_info_t           op_info,
    output smds_pkg::cnt_state_t         cnt_state
);
    import smds_pkg::*;

    localparam logic [CNT_W-1:0] TOP_IDX   = CNT_W'(DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W+1)'(DEPTH);

    logic [CNT_W-1:0] lower_count_reg, lower_count_next;
    logic [CNT_W-1:0] upper_count_reg, upper_count_next;
    logic [CNT_W:0]   used_sum;
    logic             full;
    logic [CNT_W-1:0] lower_dec;
    logic [CNT_W-1:0] upper_dec;
    logic [CNT_W-1:0] upper_push_idx;
    logic [CNT_W-1:0] upper_pop_idx;
    logic [CNT_W-1:0] lower_cnt_n;
    logic [CNT_W-1:0] upper_cnt_n;

    assign used_sum       = {1'b0, lower_count_reg} + {1'b0, upper_count_reg};
    assign full           = (used_sum >= DEPTH_SUM);
    assign lower_dec      = lower_count_reg - CNT_W'(1);
    assign upper_dec      = upper_count_reg - CNT_W'(1);
    assign upper_push_idx = TOP_IDX - upper_count_reg;
    assign upper_pop_idx  = TOP_IDX - upper_dec;

    always_comb
    begin
        mem_req            = '0;
        mem_req.wdata      = req.entry_data;
        op_info            = '0;
        op_info.status     = STATUS_OK;
        lower_cnt_n        = lower_count_reg;
        upper_cnt_n        = upper_count_reg;

        if (req.func == FUNC_PUSH)
        begin
            if (full)
            begin
                op_info.status = STATUS_FULL;
            end
            else if (req.score >= route_threshold)
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = lower_count_reg[ADDR_W-1:0];
                lower_cnt_n  = lower_count_reg + CNT_W'(1);
            end
            else
            begin
                mem_req.we         = 1'b1;
                mem_req.addr       = upper_push_idx[ADDR_W-1:0];
                upper_cnt_n        = upper_count_reg + CNT_W'(1);
                op_info.went_upper = 1'b1;
            end
        end
        else if (req.stack_select == SEL_LOWER)
        begin
            if (lower_count_reg == '0)
            begin
                op_info.status = STATUS_EMPTY;
            end
            else
            begin
                mem_req.re    = 1'b1;
                mem_req.addr  = lower_dec[ADDR_W-1:0];
                lower_cnt_n   = lower_dec;
                op_info.rd_ok = 1'b1;
            end
        end
        else
        begin
            if (upper_count_reg == '0)
            begin
                op_info.status = STATUS_EMPTY;
            end
            else
            begin
                mem_req.re    = 1'b1;
                mem_req.addr  = upper_pop_idx[ADDR_W-1:0];
                upper_cnt_n   = upper_dec;
                op_info.rd_ok = 1'b1;
            end
        end

        // only a real transaction touches the store
        if (!accept)
        begin
            mem_req.we = 1'b0;
            mem_req.re = 1'b0;
        end
    end

    assign lower_count_next = accept ? lower_cnt_n : lower_count_reg;
    assign upper_count_next = accept ? upper_cnt_n : upper_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_count_reg <= '0;
            upper_count_reg <= '0;
        end
        else
        begin
            lower_count_reg <= lower_count_next;
            upper_count_reg <= upper_count_next;
        end
    end

    assign cnt_state.lower_count = lower_count_reg;
    assign cnt_state.upper_count = upper_count_reg;

endmodule

@@ rtl/shared_memory_dual_stack.sv @@
// Two stacks in one 16-entry store: the lower stack grows up from entry 0, the upper stack
// grows down from the last entry. A push goes to the lower stack when its score is at or
// above route_threshold (apb register 0, reset 70), else to the upper stack; a pop names the
// stack. Each transaction on req yields exactly one result on rsp. The block takes one
// operation per cycle while rsp is not stalled. A result passes from the memory stage
// register through the output register before it is valid on rsp. The stack counters update
// at acceptance, and the store is a single-port synchronous memory whose registered read data
// is joined with the status in the output register; a held result stops new requests only
// while the memory stage is also occupied. A push that finds both stacks together holding all
// entries returns full; a pop of an empty stack returns empty; read_data is zero except on a
// successful pop.
`include "assert_macros.svh"

module shared_memory_dual_stack (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smds_pkg::APB_AW-1:0] paddr,
    input  logic [smds_pkg::APB_DW-1:0] pwdata,
    output logic [smds_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    smds_req_if.sink                    req,
    smds_rsp_if.source                  rsp
);
    import smds_pkg::*;

    logic [SCORE_W-1:0]    route_threshold;
    req_t                  req_data;
    mem_req_t              mem_req;
    op_info_t              op_info;
    cnt_state_t            cnt_state;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic                  accept;
    logic                  out_load;
    logic                  s1_fire;

    logic                  s1_valid_reg, s1_valid_next;
    op_info_t              s1_info_reg, s1_info_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_data_reg, out_data_next;
    status_t               out_status_reg, out_status_next;
    logic                  out_upper_reg, out_upper_next;

    smds_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .route_threshold (route_threshold)
    );

    assign req_data.func         = req.func;
    assign req_data.entry_data   = req.entry_data;
    assign req_data.score        = req.score;
    assign req_data.stack_select = req.stack_select;

    // output register frees up this cycle, so the memory stage may move on
    assign out_load  = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && out_load;
    assign req.ready = !s1_valid_reg || out_load;
    assign accept    = req.valid && req.ready;

    smds_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .req             (req_data),
        .route_threshold (route_threshold),
        .mem_req         (mem_req),
        .op_info         (op_info),
        .cnt_state       (cnt_state)
    );

    smds_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (mem_rdata)
    );

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        s1_info_next    = s1_info_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_upper_next  = out_upper_reg;

        if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_info_next  = op_info;
        end

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_fire)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = s1_info_reg.rd_ok ? mem_rdata : '0;
            out_status_next = s1_info_reg.status;
            out_upper_next  = s1_info_reg.went_upper;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_info_reg    <= s1_info_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_upper_reg  <= out_upper_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.went_upper = out_upper_reg;

    `SMDS_ASSERT(a_count_bound, clk, rst_n,
        ({1'b0, cnt_state.lower_count} + {1'b0, cnt_state.upper_count}) <= (CNT_W+1)'(DEPTH))

    `SMDS_ASSERT_NEVER(a_one_access, clk, rst_n, mem_req.we && mem_req.re)

    `SMDS_ASSERT(a_rdata_held, clk, rst_n,
        (s1_valid_reg && s1_info_reg.rd_ok && !out_load) |=> $stable(mem_rdata))

    `SMDS_ASSERT(a_fail_clean, clk, rst_n,
        (rsp.valid && (rsp.status != STATUS_OK)) |-> ((rsp.read_data == '0) && !rsp.went_upper))

endmodule

@@ verif/shared_memory_dual_stack_test.sv @@
// testbench for the shared-memory dual stack: directed and random push/pop traffic checked against a predictor
`timescale 1ns / 1ps

module shared_memory_dual_stack_test;
    import smds_pkg::*;

    localparam int RAND_PHASES    = 9;
    localparam int OPS_PER_PHASE  = 160;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_PAUSE      = 8;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        status_t               status;
        logic                  went_upper;
    } stack_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    smds_req_if req_ch ();
    smds_rsp_if rsp_ch ();

    shared_memory_dual_stack dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [DATA_WIDTH-1:0] shadow_store [DEPTH];
    logic [CNT_W-1:0]      lower_cnt;
    logic [CNT_W-1:0]      upper_cnt;
    logic [SCORE_W-1:0]    route_thresh;

    req_t          pending_ops [$];
    stack_result_t expected_results [$];

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int error_count    = 0;
    int idle_cycles    = 0;

    logic [APB_DW-1:0] thresh_words [RAND_PHASES-1] = '{
        32'd0, 32'd100, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FF80 | 32'd50,
        32'd0, 32'd99, 32'd70
    };

    function automatic stack_result_t apply_stack_op(input req_t op);
        stack_result_t res;
        res = '{read_data: '0, status: STATUS_OK, went_upper: 1'b0};
        if (op.func == FUNC_PUSH)
        begin
            if (lower_cnt + upper_cnt >= DEPTH)
                res.status = STATUS_FULL;
            else if (op.score >= route_thresh)
            begin
                shadow_store[lower_cnt] = op.entry_data;
                lower_cnt = lower_cnt + 1'b1;
            end
            else
            begin
                shadow_store[DEPTH - 1 - upper_cnt] = op.entry_data;
                upper_cnt = upper_cnt + 1'b1;
                res.went_upper = 1'b1;
            end
        end
        else if (op.stack_select == SEL_LOWER)
        begin
            if (lower_cnt == 0)
                res.status = STATUS_EMPTY;
            else
            begin
                lower_cnt = lower_cnt - 1'b1;
                res.read_data = shadow_store[lower_cnt];
            end
        end
        else
        begin
            if (upper_cnt == 0)
                res.status = STATUS_EMPTY;
            else
            begin
                upper_cnt = upper_cnt - 1'b1;
                res.read_data = shadow_store[DEPTH - 1 - upper_cnt];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [APB_DW-1:0] got,
                                   input logic [APB_DW-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic queue_op(input logic func, input logic [DATA_WIDTH-1:0] data,
                            input logic [SCORE_W-1:0] score, input logic sel);
        pending_ops.push_back('{func: func, entry_data: data, score: score, stack_select: sel});
    endtask

    function automatic req_t make_random_op(input int push_pct);
        req_t op;
        int   pick;
        op.func         = ($urandom_range(99, 0) < push_pct) ? FUNC_PUSH : FUNC_POP;
        op.stack_select = 1'($urandom_range(1, 0));
        pick = $urandom_range(15, 0);
        op.entry_data = (pick == 0) ? '0 : (pick == 1) ? '1 : DATA_WIDTH'($urandom());
        pick = $urandom_range(9, 0);
        if (pick < 2)
            // right at the routing boundary
            op.score = SCORE_W'(int'(route_thresh) - 1 + $urandom_range(2, 0));
        else if (pick == 2)
            op.score = SCORE_W'($urandom_range(127, 101));
        else
            op.score = SCORE_W'($urandom_range(100, 0));
        return op;
    endfunction

    task automatic apb_access(input logic is_write, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_AW'({REG_ROUTE_THRESHOLD, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_threshold(input logic [APB_DW-1:0] word);
        logic [APB_DW-1:0] rdata;
        apb_access(1'b1, word, rdata);
        route_thresh = word[SCORE_W-1:0];
        apb_access(1'b0, '0, rdata);
        if (rdata !== APB_DW'(route_thresh))
            report_mismatch("route_threshold readback", rdata, APB_DW'(route_thresh));
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0);
    endtask

    // request driver
    always @(posedge clk)
    begin
        req_t next_op;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(apply_stack_op('{func: req_ch.func,
                    entry_data: req_ch.entry_data, score: req_ch.score,
                    stack_select: req_ch.stack_select}));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    next_op = pending_ops.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.func         <= next_op.func;
                    req_ch.entry_data   <= next_op.entry_data;
                    req_ch.score        <= next_op.score;
                    req_ch.stack_select <= next_op.stack_select;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        stack_result_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no request outstanding",
                                    APB_DW'(rsp_ch.status), '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.read_data !== want.read_data)
                        report_mismatch("read_data", rsp_ch.read_data, want.read_data);
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", APB_DW'(rsp_ch.status), APB_DW'(want.status));
                    if (rsp_ch.went_upper !== want.went_upper)
                        report_mismatch("went_upper", APB_DW'(rsp_ch.went_upper),
                                        APB_DW'(want.went_upper));
                end
            end
            rsp_ch.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
        end
    end

    // watchdog: any transaction or register access counts as progress
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("shared_memory_dual_stack_test failed");
            $finish;
        end
    end

    initial
    begin
        int               n_ops;
        int               burst_left;
        int               push_pct;
        logic [APB_DW-1:0] word;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.func         = FUNC_PUSH;
        req_ch.entry_data   = '0;
        req_ch.score        = '0;
        req_ch.stack_select = SEL_LOWER;
        rsp_ch.ready        = 1'b0;

        lower_cnt    = '0;
        upper_cnt    = '0;
        route_thresh = THRESH_RESET;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty pops, pop of one stack while the other holds data,
        // filling the store from both ends, pushes into a full store
        queue_op(FUNC_POP, $urandom(), 7'd127, SEL_LOWER);
        queue_op(FUNC_POP, $urandom(), 7'd0, SEL_UPPER);
        queue_op(FUNC_PUSH, '1, 7'd69, SEL_LOWER);
        queue_op(FUNC_POP, '0, 7'd100, SEL_LOWER);
        queue_op(FUNC_POP, '0, 7'd0, SEL_UPPER);
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i % 8)
                0: queue_op(FUNC_PUSH, '0, 7'd70, SEL_UPPER);
                1: queue_op(FUNC_PUSH, '1, 7'd0, SEL_LOWER);
                2: queue_op(FUNC_PUSH, 32'hA5A5_A5A5, 7'd100, SEL_LOWER);
                3: queue_op(FUNC_PUSH, 32'h5A5A_5A5A, 7'd69, SEL_UPPER);
                4: queue_op(FUNC_PUSH, $urandom(), 7'd127, SEL_LOWER);
                5: queue_op(FUNC_PUSH, $urandom(), 7'd1, SEL_UPPER);
                6: queue_op(FUNC_PUSH, $urandom(), 7'd101, SEL_UPPER);
                default: queue_op(FUNC_PUSH, $urandom(), 7'd50, SEL_LOWER);
            endcase
        end
        queue_op(FUNC_PUSH, '1, 7'd0, SEL_UPPER);
        queue_op(FUNC_PUSH, '1, 7'd127, SEL_LOWER);
        queue_op(FUNC_POP, '0, 7'd0, SEL_LOWER);
        queue_op(FUNC_POP, '1, 7'd127, SEL_UPPER);
        wait_drained();

        for (int k = 0; k < RAND_PHASES; k++)
        begin
            // first phase runs at the reset threshold
            if (k > 0)
            begin
                word = thresh_words[k-1];
                if (k == 6)
                    word = ($urandom() & ~32'h7F) | $urandom_range(100, 0);
                set_threshold(word);
                @(negedge clk);
            end
            case (k % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 54; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 54; end
                default: begin send_idle_pct = 13; sink_stall_pct = 13; end
            endcase
            // bursts that lean toward pushes or pops so both full and empty are hit
            n_ops      = 0;
            burst_left = 0;
            push_pct   = 50;
            while (n_ops < OPS_PER_PHASE)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(40, 8);
                    case ($urandom_range(2, 0))
                        0: push_pct = 20;
                        1: push_pct = 50;
                        default: push_pct = 80;
                    endcase
                end
                pending_ops.push_back(make_random_op(push_pct));
                burst_left--;
                n_ops++;
            end
            wait_drained();
        end

        repeat (END_PAUSE)
            @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("shared_memory_dual_stack_test passed");
        else
            $display("shared_memory_dual_stack_test failed");
        $finish;
    end

endmodule

@@ shared_memory_dual_stack.f @@
+incdir+rtl
rtl/smds_pkg.sv
rtl/smds_if.sv
rtl/smds_cfg.sv
rtl/smds_mem.sv
rtl/smds_ctrl.sv
rtl/shared_memory_dual_stack.sv
verif/shared_memory_dual_stack_test.sv
